>>> rtl/pans_pkg.sv
// Shared constants, types and pitch helper functions of the note sequencer.
package pans_pkg;

  localparam int NUM_VOICES      = 4;
  localparam int NOTES_PER_VOICE = 1024;
  localparam int VOICE_W         = $clog2(NUM_VOICES);
  localparam int IDX_W           = $clog2(NOTES_PER_VOICE);
  localparam int POS_W           = IDX_W + 1;
  localparam int ADDR_W          = VOICE_W + IDX_W;
  localparam int ENTRY_W         = 48;
  localparam int VC_W            = 3;

  // Note entry layout
  localparam int E_PITCH  = 0;
  localparam int E_TRILLP = 7;
  localparam int E_TICK   = 15;
  localparam int E_TIED   = 46;
  localparam int E_TRILL  = 47;

  localparam logic [3:0] OP_LOAD     = 4'd0;
  localparam logic [3:0] OP_PLAY_ALL = 4'd1;
  localparam logic [3:0] OP_PLAY_ONE = 4'd2;
  localparam logic [3:0] OP_STOP_ALL = 4'd3;
  localparam logic [3:0] OP_STOP_ONE = 4'd4;
  localparam logic [3:0] OP_REWIND   = 4'd5;
  localparam logic [3:0] OP_ADVANCE  = 4'd6;
  localparam logic [3:0] OP_TRILL    = 4'd7;
  localparam logic [3:0] OP_CLEAR    = 4'd8;

  localparam logic [1:0] KIND_OFF    = 2'd0;
  localparam logic [1:0] KIND_ON     = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic REG_VOICE_COUNT  = 1'b0;
  localparam logic REG_PITCH_OFFSET = 1'b1;

  localparam logic [6:0] PITCH_MAX = 7'd127;
  localparam logic [3:0] SCALE_STEPS [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};

  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ADDR_W-1:0]    rd_addr;
  } mem_req_t;

  // x mod 12 for x below 128, by reciprocal multiply
  function automatic logic [3:0] mod12(input logic [6:0] x);
    logic [12:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = 13'(x) * 13'd43;
    q    = prod[12:9];
    r    = x - 7'(q) * 7'd12;
    return r[3:0];
  endfunction

  // Diatonic upper neighbour; chromatic pitches take a whole step
  function automatic logic [7:0] upper_pitch(input logic [6:0] p,
                                             input logic signed [3:0] key);
    logic signed [7:0] ks;
    logic [3:0] tonic, pc;
    logic [4:0] s, n, d;
    logic [7:0] up;
    ks    = 8'(key) * 8'sd7 + 8'sd60;
    tonic = mod12(ks[6:0]);
    pc    = mod12(p);
    up    = 8'(p) + 8'd2;
    for (int i = 0; i < 7; i++) begin
      s = 5'(tonic) + 5'(SCALE_STEPS[i]);
      if (s >= 5'd12) s = s - 5'd12;
      n = 5'(tonic) + 5'(SCALE_STEPS[(i == 6) ? 0 : i + 1]);
      if (n >= 5'd12) n = n - 5'd12;
      d = n + 5'd12 - 5'(pc);
      if (d >= 5'd12) d = d - 5'd12;
      if (s[3:0] == pc) up = 8'(p) + 8'(d);
    end
    return up;
  endfunction

  function automatic logic [6:0] clamp_pitch(input logic [7:0] x,
                                             input logic signed [5:0] off);
    logic signed [9:0] s;
    s = signed'({2'b00, x}) + 10'(off);
    if (s < 10'sd0) return 7'd0;
    if (s > 10'sd127) return PITCH_MAX;
    return s[6:0];
  endfunction

endpackage

>>> rtl/pans_note_mem.sv
// Note table: single-port write, registered read, one entry per note.
module pans_note_mem
  import pans_pkg::*;
(
  input  logic               clk_i,
  input  mem_req_t           req_i,
  output logic [ENTRY_W-1:0] rd_data_o
);

  logic [ENTRY_W-1:0] mem_q [NUM_VOICES*NOTES_PER_VOICE];
  logic [ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_q <= mem_q[req_i.rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/pans_seq.sv
// Sequencer: walks the voices, reads and updates note entries, emits note beats.
module pans_seq
  import pans_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             op_i,
  input  logic [VOICE_W-1:0]     voice_i,
  input  logic [6:0]             note_pitch_i,
  input  logic [30:0]            note_tick_i,
  input  logic                   tied_i,
  input  logic                   has_trill_i,
  input  logic signed [3:0]      key_fifths_i,
  input  logic [VC_W-1:0]        active_i,
  input  logic signed [5:0]      offset_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             out_kind_o,
  output logic [VOICE_W-1:0]     out_channel_o,
  output logic [6:0]             out_pitch_o,
  output logic                   out_advanced_o,
  output logic                   out_trill_o,
  output logic                   out_full_o,
  output logic                   out_last_o,
  output mem_req_t               mem_req_o,
  input  logic [ENTRY_W-1:0]     mem_rd_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_VOICE = 9'b000000010,
    S_EVAL  = 9'b000000100,
    S_OFF   = 9'b000001000,
    S_ON    = 9'b000010000,
    S_SKIP  = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_TRL   = 9'b010000000,
    S_STAT  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]         op_q, op_d;
  logic [VC_W-1:0]    v_q, v_d, end_q, end_d;
  logic [30:0]        tick_q, tick_d;
  logic               skip_q, skip_d, on_pend_q, on_pend_d;
  logic [6:0]         off_q, off_d, on_q, on_d;
  logic               adv_q, adv_d, full_q, full_d, tu_q, tu_d;
  logic [POS_W-1:0]   cnt_q [NUM_VOICES];
  logic [POS_W-1:0]   cnt_d [NUM_VOICES];
  logic [POS_W-1:0]   pos_q [NUM_VOICES];
  logic [POS_W-1:0]   pos_d [NUM_VOICES];
  logic               sv_q  [NUM_VOICES];
  logic               sv_d  [NUM_VOICES];
  logic [6:0]         sp_q  [NUM_VOICES];
  logic [6:0]         sp_d  [NUM_VOICES];
  logic               ov_q, ov_d, olast_q, olast_d, oadv_q, oadv_d;
  logic               otr_q, otr_d, ofull_q, ofull_d;
  logic [1:0]         okind_q, okind_d;
  logic [VOICE_W-1:0] och_q, och_d;
  logic [6:0]         op_pitch_q, op_pitch_d;

  logic [VOICE_W-1:0] vi, first_v;
  logic               first_hit, out_free;
  logic [POS_W-1:0]   cur_pos, cur_cnt, pos_m1, first_pm1;
  logic [6:0]         e_pitch;
  logic [7:0]         e_up;
  logic [30:0]        e_tick;
  logic               e_tied, e_trill;

  assign vi       = v_q[VOICE_W-1:0];
  assign cur_pos  = pos_q[vi];
  assign cur_cnt  = cnt_q[vi];
  assign pos_m1   = cur_pos - POS_W'(1);
  assign out_free = !ov_q || out_ready_i;
  assign e_pitch  = mem_rd_i[E_PITCH +: 7];
  assign e_up     = mem_rd_i[E_TRILLP +: 8];
  assign e_tick   = mem_rd_i[E_TICK +: 31];
  assign e_tied   = mem_rd_i[E_TIED];
  assign e_trill  = mem_rd_i[E_TRILL];

  // First active voice that has played a note
  always_comb begin
    first_v   = '0;
    first_hit = 1'b0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (VC_W'(i) < active_i && pos_q[i] != '0 && pos_q[i] <= cnt_q[i]) begin
        first_v   = VOICE_W'(i);
        first_hit = 1'b1;
      end
    end
    first_pm1 = pos_q[first_v] - POS_W'(1);
  end

  always_comb begin
    state_d = state_q; op_d = op_q; v_d = v_q; end_d = end_q; tick_d = tick_q;
    skip_d = skip_q; on_pend_d = on_pend_q; off_d = off_q; on_d = on_q;
    adv_d = adv_q; full_d = full_q; tu_d = tu_q;
    cnt_d = cnt_q; pos_d = pos_q; sv_d = sv_q; sp_d = sp_q;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q; och_d = och_q; op_pitch_d = op_pitch_q;
    oadv_d = oadv_q; otr_d = otr_q; ofull_d = ofull_q; olast_d = olast_q;
    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = {voice_i, cnt_q[voice_i][IDX_W-1:0]};
    mem_req_o.wr_data = {has_trill_i, tied_i, note_tick_i,
                         has_trill_i ? upper_pitch(note_pitch_i, key_fifths_i)
                                     : {1'b0, note_pitch_i},
                         note_pitch_i};
    mem_req_o.rd_addr = {vi, cur_pos[IDX_W-1:0]};
    if (op_q == OP_TRILL) mem_req_o.rd_addr = {vi, pos_m1[IDX_W-1:0]};
    if (state_q == S_TRL || state_q == S_STAT) begin
      mem_req_o.rd_addr = {first_v, first_pm1[IDX_W-1:0]};
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = op_i; tick_d = note_tick_i; adv_d = 1'b0; full_d = 1'b0;
          skip_d = 1'b0; v_d = '0; end_d = active_i; state_d = S_VOICE;
          priority if (op_i == OP_LOAD) begin
            state_d = S_FIN;
            if (cnt_q[voice_i] == POS_W'(NOTES_PER_VOICE)) begin
              full_d = 1'b1;
            end else begin
              mem_req_o.wr_en = 1'b1;
              cnt_d[voice_i] = cnt_q[voice_i] + POS_W'(1);
            end
          end else if (op_i == OP_PLAY_ONE || op_i == OP_STOP_ONE) begin
            v_d   = VC_W'(voice_i);
            end_d = (VC_W'(voice_i) < active_i) ? VC_W'(voice_i) + VC_W'(1)
                                                : VC_W'(voice_i);
          end else if (op_i > OP_CLEAR) begin
            end_d = '0;
          end else begin
            end_d = active_i;
          end
        end
      end
      S_VOICE: begin
        v_d = v_q + VC_W'(1);
        skip_d = 1'b0;
        if (v_q >= end_q) begin
          v_d = v_q;
          state_d = S_FIN;
        end else begin
          unique case (op_q)
            OP_PLAY_ALL, OP_PLAY_ONE, OP_ADVANCE: begin
              if (cur_pos < cur_cnt) begin
                v_d = v_q;
                state_d = S_EVAL;
              end
            end
            OP_TRILL: begin
              if (cur_pos != '0 && cur_pos <= cur_cnt) begin
                v_d = v_q;
                state_d = S_EVAL;
              end
            end
            OP_STOP_ALL, OP_STOP_ONE, OP_REWIND, OP_CLEAR: begin
              if (op_q == OP_REWIND) pos_d[vi] = '0;
              if (sv_q[vi]) begin
                v_d = v_q; off_d = sp_q[vi]; on_pend_d = 1'b0; state_d = S_OFF;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_EVAL: begin
        v_d = v_q + VC_W'(1);
        state_d = S_VOICE;
        skip_d = 1'b0;
        priority if (op_q == OP_ADVANCE) begin
          if (e_tied && e_tick <= tick_q) begin
            v_d = v_q; pos_d[vi] = cur_pos + POS_W'(1); adv_d = 1'b1;
          end
        end else if (op_q == OP_TRILL) begin
          if (e_trill) begin
            v_d = v_q; on_pend_d = 1'b1; state_d = S_OFF;
            off_d = clamp_pitch(tu_q ? e_up : {1'b0, e_pitch}, offset_i);
            on_d  = clamp_pitch(tu_q ? {1'b0, e_pitch} : e_up, offset_i);
          end
        end else if (skip_q) begin
          // drop tied continuation notes
          if (e_tied) begin
            v_d = v_q; skip_d = 1'b1; pos_d[vi] = cur_pos + POS_W'(1); state_d = S_SKIP;
          end
        end else begin
          v_d = v_q; on_pend_d = 1'b1; off_d = sp_q[vi];
          on_d = clamp_pitch({1'b0, e_pitch}, offset_i);
          state_d = sv_q[vi] ? S_OFF : S_ON;
        end
      end
      S_OFF: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_OFF; och_d = vi; op_pitch_d = off_q;
          oadv_d = 1'b0; otr_d = 1'b0; ofull_d = 1'b0; olast_d = 1'b0;
          sv_d[vi] = 1'b0;
          if (on_pend_q) begin
            state_d = S_ON;
          end else begin
            v_d = v_q + VC_W'(1); state_d = S_VOICE;
          end
        end
      end
      S_ON: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_ON; och_d = vi; op_pitch_d = on_q;
          oadv_d = 1'b0; otr_d = 1'b0; ofull_d = 1'b0; olast_d = 1'b0;
          sv_d[vi] = 1'b1; sp_d[vi] = on_q;
          if (op_q == OP_TRILL) begin
            v_d = v_q + VC_W'(1); state_d = S_VOICE;
          end else begin
            pos_d[vi] = cur_pos + POS_W'(1); skip_d = 1'b1; state_d = S_SKIP;
          end
        end
      end
      S_SKIP: begin
        if (cur_pos < cur_cnt) begin
          state_d = S_EVAL;
        end else begin
          v_d = v_q + VC_W'(1); skip_d = 1'b0; state_d = S_VOICE;
        end
      end
      S_FIN: begin
        if (op_q == OP_PLAY_ALL || op_q == OP_REWIND) tu_d = 1'b0;
        if (op_q == OP_TRILL) tu_d = !tu_q;
        if (op_q == OP_CLEAR) begin
          for (int i = 0; i < NUM_VOICES; i++) begin
            cnt_d[i] = '0; pos_d[i] = '0; sv_d[i] = 1'b0;
          end
        end
        state_d = S_TRL;
      end
      S_TRL: state_d = S_STAT;
      S_STAT: begin
        if (out_free) begin
          ov_d = 1'b1; okind_d = KIND_STATUS; och_d = '0; op_pitch_d = '0;
          oadv_d = adv_q; otr_d = first_hit && mem_rd_i[E_TRILL];
          ofull_d = full_q; olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      tu_q    <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        cnt_q[i] <= '0; pos_q[i] <= '0; sv_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      tu_q    <= tu_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      sv_q    <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; v_q <= v_d; end_q <= end_d; tick_q <= tick_d;
    skip_q <= skip_d; on_pend_q <= on_pend_d; off_q <= off_d; on_q <= on_d;
    adv_q <= adv_d; full_q <= full_d; sp_q <= sp_d;
    okind_q <= okind_d; och_q <= och_d; op_pitch_q <= op_pitch_d;
    oadv_q <= oadv_d; otr_q <= otr_d; ofull_q <= ofull_d; olast_q <= olast_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ov_q;
  assign out_kind_o     = okind_q;
  assign out_channel_o  = och_q;
  assign out_pitch_o    = op_pitch_q;
  assign out_advanced_o = oadv_q;
  assign out_trill_o    = otr_q;
  assign out_full_o     = ofull_q;
  assign out_last_o     = olast_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accept while busy");
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (out_kind_o == KIND_STATUS)))
    else $error("last flag on a note beat");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> state_q == S_IDLE) else $error("table write while busy");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[vi] <= POS_W'(NOTES_PER_VOICE)) else $error("note count overflow");

endmodule

>>> rtl/play_along_note_sequencer.sv
// Top level: APB registers, stream packing, sequencer and note table.
//
// Input stream: one beat per command (load, play, stop, rewind, advance
// ties, trill toggle, clear); the operation rides in tuser. Output stream:
// note-off and note-on beats, then one status beat marked by tlast.
// Configuration: voice_count at address 0, pitch_offset at address 4;
// write only while no command is in flight.
// Operation: a command is taken only while the block is idle; the walk
// visits each voice in turn, reading note entries through the single
// registered read port of the note table and emitting beats, and a play
// also steps past tied notes it skips. After the voice walk the FIN and
// TRL states lead to the STAT state, which loads the status beat.
// One command is worked on at a time; tready stays low until its status
// beat is loaded into the output register.
// Reset clears counts, positions, sounding notes and the trill phase; the
// note table itself holds no reset value and is only read below a count.
// A stalled receiver holds the output register and the walk waits for it.
module play_along_note_sequencer
  import pans_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // voice[1:0], note_pitch[8:2], note_tick[39:9], tied[40], has_trill[41],
  // key_fifths[45:42], zero[47:46]
  input  logic [47:0] s_axis_tdata_i,
  // operation[3:0]
  input  logic [3:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // channel[1:0], pitch[8:2], advanced[9], trill_current[10], table_full[11],
  // zero[15:12]
  output logic [15:0] m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [VC_W-1:0]    voice_count_q;
  logic signed [5:0]  pitch_offset_q;
  logic [VC_W-1:0]    active;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rd;
  logic [1:0]         out_channel;
  logic [6:0]         out_pitch;
  logic               out_adv, out_trl, out_full;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q  <= VC_W'(1);
      pitch_offset_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_VOICE_COUNT) voice_count_q <= pwdata[VC_W-1:0];
      else pitch_offset_q <= pwdata[5:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_VOICE_COUNT) prdata = {29'd0, voice_count_q};
    else prdata = 32'(pitch_offset_q);
  end

  // Counts above the voice limit act as the limit
  assign active = (voice_count_q > VC_W'(NUM_VOICES)) ? VC_W'(NUM_VOICES) : voice_count_q;

  pans_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .op_i           (s_axis_tuser_i),
    .voice_i        (s_axis_tdata_i[1:0]),
    .note_pitch_i   (s_axis_tdata_i[8:2]),
    .note_tick_i    (s_axis_tdata_i[39:9]),
    .tied_i         (s_axis_tdata_i[40]),
    .has_trill_i    (s_axis_tdata_i[41]),
    .key_fifths_i   (s_axis_tdata_i[45:42]),
    .active_i       (active),
    .offset_i       (pitch_offset_q),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_kind_o     (m_axis_tuser_o),
    .out_channel_o  (out_channel),
    .out_pitch_o    (out_pitch),
    .out_advanced_o (out_adv),
    .out_trill_o    (out_trl),
    .out_full_o     (out_full),
    .out_last_o     (m_axis_tlast_o),
    .mem_req_o      (mem_req),
    .mem_rd_i       (mem_rd)
  );

  pans_note_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd)
  );

  assign m_axis_tdata_o = {4'd0, out_full, out_trl, out_adv, out_pitch, out_channel};

endmodule

>>> tb/tb.sv
// Self-checking testbench of the play-along note sequencer with its own event predictor.
module tb
  import pans_pkg::*;
;

  localparam int LIMIT  = 600000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [3:0]  op;
    logic [1:0]  voice;
    logic [6:0]  pitch;
    logic [30:0] tick;
    logic        tied;
    logic        trill;
    logic [3:0]  key;
  } cmd_t;

  typedef struct {
    logic [1:0] kind;
    logic [1:0] chan;
    logic [6:0] pitch;
    logic       adv;
    logic       trl;
    logic       full;
    logic       last;
  } note_evt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  play_along_note_sequencer u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser), .m_axis_tlast_o(m_tlast),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [6:0]  tbl_pitch [NUM_VOICES][NOTES_PER_VOICE];
  logic [7:0]  tbl_upper [NUM_VOICES][NOTES_PER_VOICE];
  logic [30:0] tbl_tick  [NUM_VOICES][NOTES_PER_VOICE];
  logic        tbl_tied  [NUM_VOICES][NOTES_PER_VOICE];
  logic        tbl_trill [NUM_VOICES][NOTES_PER_VOICE];
  int          note_cnt [NUM_VOICES];
  int          play_pos [NUM_VOICES];
  bit          snd_on [NUM_VOICES];
  logic [6:0]  snd_pitch [NUM_VOICES];
  bit          trill_hi;
  int          voice_cfg;
  int          offset_cfg;

  cmd_t        cmd_q[$];
  note_evt_t   event_q[$];
  cmd_t        cur_cmd;
  int          err_cnt, beats_in, beats_out, cycles;
  int          burst_left, gap_left, stall_pct;
  int          hold_left;
  bit          hold_req, hold_done;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at cycle %0d: %s", cycles, msg);
    err_cnt++;
  endtask

  function automatic void queue_cmd(input cmd_t c);
    cmd_q = {cmd_q, c};
  endfunction

  function automatic logic [7:0] trill_neighbor(input logic [6:0] p, input logic [3:0] k);
    int steps[7] = '{0, 2, 4, 5, 7, 9, 11};
    int key, tonic, pc, nxt;
    key   = $signed(k);
    tonic = ((key * 7) % 12 + 12) % 12;
    pc    = p % 12;
    for (int i = 0; i < 7; i++) begin
      if ((tonic + steps[i]) % 12 == pc) begin
        nxt = (tonic + steps[(i + 1) % 7]) % 12;
        return 8'(int'(p) + (nxt - pc + 12) % 12);
      end
    end
    return 8'(int'(p) + 2);
  endfunction

  function automatic logic [6:0] transpose(input int p);
    int q;
    q = p + offset_cfg;
    if (q < 0) q = 0;
    if (q > 127) q = 127;
    return 7'(q);
  endfunction

  function automatic void push_evt(input logic [1:0] kind, input int ch, input logic [6:0] p);
    note_evt_t e;
    e = '{kind, 2'(ch), p, 1'b0, 1'b0, 1'b0, 1'b0};
    event_q = {event_q, e};
  endfunction

  function automatic void silence(input int v);
    if (snd_on[v]) begin
      push_evt(KIND_OFF, v, snd_pitch[v]);
      snd_on[v] = 0;
    end
  endfunction

  function automatic void sound_next(input int v);
    logic [6:0] p;
    if (play_pos[v] >= note_cnt[v]) return;
    p = transpose(tbl_pitch[v][play_pos[v]]);
    if (snd_on[v]) push_evt(KIND_OFF, v, snd_pitch[v]);
    push_evt(KIND_ON, v, p);
    snd_on[v] = 1;
    snd_pitch[v] = p;
    play_pos[v]++;
    // skip tied continuations
    while (play_pos[v] < note_cnt[v] && tbl_tied[v][play_pos[v]]) play_pos[v]++;
  endfunction

  // Work out every event one command causes and queue it.
  function automatic void play_item(input cmd_t c);
    int nv, v, np;
    logic adv, full, trl;
    logic [6:0] oldp, newp;
    note_evt_t st;
    nv   = (voice_cfg > NUM_VOICES) ? NUM_VOICES : voice_cfg;
    v    = c.voice;
    adv  = 0;
    full = 0;
    case (c.op)
      OP_LOAD: begin
        if (note_cnt[v] >= NOTES_PER_VOICE) full = 1;
        else begin
          np = note_cnt[v];
          tbl_pitch[v][np] = c.pitch;
          tbl_upper[v][np] = c.trill ? trill_neighbor(c.pitch, c.key) : 8'(c.pitch);
          tbl_tick[v][np]  = c.tick;
          tbl_tied[v][np]  = c.tied;
          tbl_trill[v][np] = c.trill;
          note_cnt[v]++;
        end
      end
      OP_PLAY_ALL: begin
        for (int i = 0; i < nv; i++) sound_next(i);
        trill_hi = 0;
      end
      OP_PLAY_ONE: if (v < nv) sound_next(v);
      OP_STOP_ALL: for (int i = 0; i < nv; i++) silence(i);
      OP_STOP_ONE: if (v < nv) silence(v);
      OP_REWIND: begin
        for (int i = 0; i < nv; i++) begin
          silence(i);
          play_pos[i] = 0;
        end
        trill_hi = 0;
      end
      OP_ADVANCE: begin
        for (int i = 0; i < nv; i++)
          while (play_pos[i] < note_cnt[i] && tbl_tied[i][play_pos[i]] &&
                 tbl_tick[i][play_pos[i]] <= c.tick) begin
            play_pos[i]++;
            adv = 1;
          end
      end
      OP_TRILL: begin
        for (int i = 0; i < nv; i++) begin
          np = play_pos[i];
          if (np < 1 || np - 1 >= note_cnt[i] || !tbl_trill[i][np-1]) continue;
          oldp = transpose(trill_hi ? tbl_upper[i][np-1] : tbl_pitch[i][np-1]);
          newp = transpose(trill_hi ? tbl_pitch[i][np-1] : tbl_upper[i][np-1]);
          push_evt(KIND_OFF, i, oldp);
          push_evt(KIND_ON, i, newp);
          snd_on[i] = 1;
          snd_pitch[i] = newp;
        end
        trill_hi = !trill_hi;
      end
      OP_CLEAR: begin
        for (int i = 0; i < nv; i++) silence(i);
        for (int i = 0; i < NUM_VOICES; i++) begin
          note_cnt[i] = 0;
          play_pos[i] = 0;
          snd_on[i]   = 0;
        end
      end
      default: ;
    endcase
    trl = 0;
    for (int i = 0; i < nv; i++) begin
      np = play_pos[i];
      if (np >= 1 && np - 1 < note_cnt[i]) begin
        trl = tbl_trill[i][np-1];
        break;
      end
    end
    st = '{KIND_STATUS, 2'd0, 7'd0, adv, trl, full, 1'b1};
    event_q = {event_q, st};
  endfunction

  // sender: bursts of beats with random gaps
  always @(posedge clk_i) begin
    cmd_t c;
    bit holding;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        play_item(cur_cmd);
        beats_in++;
      end
      holding = s_tvalid && !s_tready;
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          c = cmd_q.pop_front();
          cur_cmd  = c;
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, c.key, c.trill, c.tied, c.tick, c.pitch, c.voice};
          s_tuser  <= c.op;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: stall pattern and check of every beat
  always @(posedge clk_i) begin
    note_evt_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        beats_out++;
        got = '{m_tuser, m_tdata[1:0], m_tdata[8:2], m_tdata[9], m_tdata[10], m_tdata[11],
                m_tlast};
        if (event_q.size() == 0) begin
          report_mismatch("beat with nothing expected");
        end else begin
          want = event_q.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.chan !== want.chan)
            report_mismatch($sformatf("channel %0d, want %0d", got.chan, want.chan));
          if (got.pitch !== want.pitch)
            report_mismatch($sformatf("pitch %0d, want %0d", got.pitch, want.pitch));
          if (got.adv !== want.adv)
            report_mismatch($sformatf("advanced %0b, want %0b", got.adv, want.adv));
          if (got.trl !== want.trl)
            report_mismatch($sformatf("trill_current %0b, want %0b", got.trl, want.trl));
          if (got.full !== want.full)
            report_mismatch($sformatf("table_full %0b, want %0b", got.full, want.full));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int vc, input int off);
    apb_write({REG_VOICE_COUNT, 2'b00}, 32'(vc));
    voice_cfg = vc;
    apb_write({REG_PITCH_OFFSET, 2'b00}, 32'(6'(off)));
    offset_cfg = off;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || s_tvalid || event_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(input logic [3:0] op, input int v, input int p = 0,
                              input logic [30:0] tk = 0, input bit td = 0,
                              input bit tr = 0, input int k = 0);
    cmd_t c;
    c = '{op, 2'(v), 7'(p), tk, td, tr, 4'(k)};
    return c;
  endfunction

  // mostly loads and plays so that voices actually walk their tables
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c.voice = 2'($urandom_range(0, 3));
    c.pitch = 7'($urandom_range(0, 127));
    c.tick  = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 200));
    c.tied  = ($urandom_range(0, 2) == 0);
    c.trill = ($urandom_range(0, 2) == 0);
    c.key   = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 36)      c.op = OP_LOAD;
    else if (r < 56) c.op = OP_PLAY_ALL;
    else if (r < 68) c.op = OP_PLAY_ONE;
    else if (r < 76) c.op = OP_TRILL;
    else if (r < 83) c.op = OP_ADVANCE;
    else if (r < 87) c.op = OP_STOP_ALL;
    else if (r < 91) c.op = OP_STOP_ONE;
    else if (r < 95) c.op = OP_REWIND;
    else if (r < 97) c.op = OP_CLEAR;
    else             c.op = 4'($urandom_range(9, 15));
    return c;
  endfunction

  initial begin
    int vcs[7]  = '{1, 4, 4, 0, 7, 2, 3};
    int offs[7] = '{0, 24, -24, 5, -1, 13, -7};
    int stl[7]  = '{30, 0, 50, 20, 25, 10, 40};
    for (int i = 0; i < NUM_VOICES; i++) begin
      note_cnt[i] = 0;
      play_pos[i] = 0;
      snd_on[i]   = 0;
      snd_pitch[i] = '0;
    end
    trill_hi   = 0;
    voice_cfg  = 1;
    offset_cfg = 0;
    stall_pct  = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every operation, trill keys, chromatic trill
    set_config(4, 0);
    queue_cmd(mk(OP_LOAD, 0, 0, 31'h7fffffff, 0, 1, -7));
    queue_cmd(mk(OP_LOAD, 0, 127, 5, 1, 1, 7));
    queue_cmd(mk(OP_LOAD, 0, 61, 10, 0, 1, 0));
    queue_cmd(mk(OP_LOAD, 1, 64, 0, 0, 1, -8));
    queue_cmd(mk(OP_LOAD, 1, 65, 3, 1, 0, 0));
    queue_cmd(mk(OP_LOAD, 1, 66, 4, 1, 0, 0));
    queue_cmd(mk(OP_LOAD, 1, 67, 9, 0, 0, 0));
    queue_cmd(mk(OP_LOAD, 3, 127, 0, 0, 1, 3));
    queue_cmd(mk(OP_PLAY_ALL, 0));
    queue_cmd(mk(OP_TRILL, 0));
    queue_cmd(mk(OP_TRILL, 0));
    queue_cmd(mk(OP_PLAY_ONE, 0));
    queue_cmd(mk(OP_PLAY_ONE, 2));
    queue_cmd(mk(OP_STOP_ONE, 3));
    queue_cmd(mk(OP_ADVANCE, 0, 0, 31'h7fffffff));
    queue_cmd(mk(OP_PLAY_ALL, 0));
    queue_cmd(mk(OP_PLAY_ALL, 0));
    queue_cmd(mk(OP_STOP_ALL, 0));
    queue_cmd(mk(OP_REWIND, 0));
    queue_cmd(mk(OP_PLAY_ALL, 0));
    queue_cmd(mk(4'd15, 3, 127, 31'h7fffffff, 1, 1, -1));
    queue_cmd(mk(OP_CLEAR, 0));
    queue_cmd(mk(OP_PLAY_ALL, 0));
    drain();

    // random phases across voice counts and offsets
    for (int ph = 0; ph < 7; ph++) begin
      set_config(vcs[ph], offs[ph]);
      stall_pct = stl[ph];
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 21; n++) queue_cmd(rand_cmd());
      drain();
    end

    $display("tb: %0d commands sent, %0d result beats checked", beats_in, beats_out);
    $display("tb: exercised every operation, voice counts up to 7, offsets -24 to 24");
    if (err_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
